// ===== hw/rtl/gwr_pkg.sv =====
// Package for the greedy word wrap unit: sizes, codes, FSM state type and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package gwr_pkg;

    // word buffer depth and derived widths
    localparam int MAX_WORD = 32;
    localparam int WL_W     = $clog2(MAX_WORD + 1);
    localparam int ADDR_W   = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int LL_W     = 9;
    localparam int CHAR_W   = 8;

    localparam logic [CHAR_W-1:0] SPACE_CHAR    = 8'h20;
    localparam logic [CHAR_W-1:0] WIDTH_DEFAULT = 8'd80;

    // input operation codes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // result kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BRK,
        S_RD,
        S_CHR,
        S_SPBRK,
        S_SP,
        S_EOP
    } t_state;

    typedef enum logic [1:0] {
        EM_EOL,
        EM_CHAR,
        EM_SPACE
    } t_emit;

    typedef enum logic [1:0] {
        LL_HOLD,
        LL_BRK_ADD,
        LL_CLR,
        LL_INC
    } t_ll_op;

    typedef struct packed {
        logic   in_ready;
        logic   emit;
        t_emit  emit_sel;
        logic   emit_last;
        t_ll_op ll_op;
        logic   idx_inc;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic is_flush;
        logic word_brk;
        logic space_brk;
        logic idx_done;
        logic out_free;
        logic eop;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/gwr_in_if.sv =====
// Input channel of the word wrap unit: one paragraph character or end marker.
// Depends on gwr_pkg.
`default_nettype none

interface gwr_in_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [gwr_pkg::CHAR_W-1:0]  char_code;

    modport source (output valid, output operation, output char_code, input ready);
    modport sink   (input valid, input operation, input char_code, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gwr_out_if.sv =====
// Output channel of the word wrap unit: one placed character or end of line.
// Depends on gwr_pkg.
`default_nettype none

interface gwr_out_if;
    logic                        valid;
    logic                        ready;
    logic                        out_kind;
    logic [gwr_pkg::CHAR_W-1:0]  out_char;
    logic                        word_cut;
    logic                        last_result;

    modport source (output valid, output out_kind, output out_char, output word_cut,
                    output last_result, input ready);
    modport sink   (input valid, input out_kind, input out_char, input word_cut,
                    input last_result, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gwr_cfg_if.sv =====
// Configuration write channel of the word wrap unit (line width register).
// Depends on gwr_pkg.
`default_nettype none

interface gwr_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [gwr_pkg::CHAR_W-1:0]  line_width;

    modport source (output valid, output line_width, input ready);
    modport sink   (input valid, input line_width, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gwr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module gwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/gwr_ctrl.sv =====
// Sequencer of the word wrap unit: steps through break test, word flush,
// space or end of line. Depends on gwr_pkg.
`default_nettype none

module gwr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire gwr_pkg::t_sts i_sts,
    output      gwr_pkg::t_cmd o_cmd
);

    gwr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gwr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gwr_pkg::S_IDLE: begin
                if (i_sts.in_valid && i_sts.is_flush) n_state = gwr_pkg::S_BRK;
            end
            gwr_pkg::S_BRK: begin
                if (!i_sts.word_brk || i_sts.out_free) n_state = gwr_pkg::S_RD;
            end
            gwr_pkg::S_RD: begin
                if (!i_sts.idx_done)  n_state = gwr_pkg::S_CHR;
                else if (i_sts.eop)   n_state = gwr_pkg::S_EOP;
                else                  n_state = gwr_pkg::S_SPBRK;
            end
            gwr_pkg::S_CHR: begin
                if (i_sts.out_free) n_state = gwr_pkg::S_RD;
            end
            gwr_pkg::S_SPBRK: begin
                if (!i_sts.space_brk || i_sts.out_free) n_state = gwr_pkg::S_SP;
            end
            gwr_pkg::S_SP, gwr_pkg::S_EOP: begin
                if (i_sts.out_free) n_state = gwr_pkg::S_IDLE;
            end
            default: n_state = gwr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.emit_sel  = gwr_pkg::EM_EOL;
        o_cmd.ll_op     = gwr_pkg::LL_HOLD;
        case (r_state)
            gwr_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
            end
            gwr_pkg::S_BRK: begin
                if (!i_sts.word_brk) begin
                    o_cmd.ll_op = gwr_pkg::LL_BRK_ADD;
                end else if (i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.ll_op = gwr_pkg::LL_BRK_ADD;
                end
            end
            gwr_pkg::S_CHR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = gwr_pkg::EM_CHAR;
                    o_cmd.idx_inc  = 1'b1;
                end
            end
            gwr_pkg::S_SPBRK: begin
                if (i_sts.space_brk && i_sts.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.ll_op = gwr_pkg::LL_CLR;
                end
            end
            gwr_pkg::S_SP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = gwr_pkg::EM_SPACE;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.ll_op     = gwr_pkg::LL_INC;
                end
            end
            gwr_pkg::S_EOP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.ll_op     = gwr_pkg::LL_CLR;
                end
            end
            default: begin
                o_cmd.in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gwr_dp.sv =====
// Datapath of the word wrap unit: word buffer, length counters, break
// compares, width register and output register. Depends on gwr_pkg, gwr_ram
// and the channel interfaces.
`default_nettype none

module gwr_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    gwr_in_if.sink             i_in,
    gwr_out_if.source          o_out,
    gwr_cfg_if.sink            i_cfg,
    input  wire gwr_pkg::t_cmd i_cmd,
    output      gwr_pkg::t_sts o_sts
);

    logic [gwr_pkg::WL_W-1:0]   r_wl, r_cnt, r_idx;
    logic                       r_ovf, r_cut, r_eop;
    logic [gwr_pkg::LL_W-1:0]   r_ll, n_ll;
    logic [gwr_pkg::CHAR_W-1:0] r_width;

    logic                       r_ovalid;
    logic                       r_okind;
    logic [gwr_pkg::CHAR_W-1:0] r_ochar, n_ochar;
    logic                       r_ocut;
    logic                       r_olast;

    logic                       take, is_flush, buf_room, ram_we;
    logic [gwr_pkg::CHAR_W-1:0] ram_rdata;
    logic [gwr_pkg::LL_W:0]     word_sum, space_sum, width_ext;
    logic                       word_brk, space_brk, out_free;

    assign take      = i_in.valid && i_cmd.in_ready;
    assign is_flush  = (i_in.operation == gwr_pkg::OP_END) ||
                       (i_in.char_code == gwr_pkg::SPACE_CHAR);
    assign buf_room  = r_wl < gwr_pkg::WL_W'(gwr_pkg::MAX_WORD);
    assign ram_we    = take && !is_flush && buf_room;

    assign width_ext = (gwr_pkg::LL_W + 1)'(r_width);
    assign word_sum  = (gwr_pkg::LL_W + 1)'(r_ll) + (gwr_pkg::LL_W + 1)'(r_cnt);
    assign space_sum = (gwr_pkg::LL_W + 1)'(r_ll) + (gwr_pkg::LL_W + 1)'(1);
    assign word_brk  = word_sum > width_ext;
    assign space_brk = space_sum > width_ext;
    assign out_free  = !r_ovalid || o_out.ready;

    gwr_ram #(
        .WIDTH (gwr_pkg::CHAR_W),
        .DEPTH (gwr_pkg::MAX_WORD)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wl[gwr_pkg::ADDR_W-1:0]),
        .i_wdata (i_in.char_code),
        .i_raddr (r_idx[gwr_pkg::ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // word buffer bookkeeping; a flush item hands the word over to the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl  <= '0;
            r_ovf <= 1'b0;
            r_cnt <= '0;
            r_idx <= '0;
            r_cut <= 1'b0;
            r_eop <= 1'b0;
        end else if (take) begin
            if (is_flush) begin
                r_cnt <= r_wl;
                r_cut <= r_ovf;
                r_eop <= (i_in.operation == gwr_pkg::OP_END);
                r_idx <= '0;
                r_wl  <= '0;
                r_ovf <= 1'b0;
            end else if (buf_room) begin
                r_wl <= r_wl + gwr_pkg::WL_W'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + gwr_pkg::WL_W'(1);
        end
    end

    always_comb begin
        case (i_cmd.ll_op)
            gwr_pkg::LL_BRK_ADD: n_ll = (word_brk ? '0 : r_ll) + gwr_pkg::LL_W'(r_cnt);
            gwr_pkg::LL_CLR:     n_ll = '0;
            gwr_pkg::LL_INC:     n_ll = r_ll + gwr_pkg::LL_W'(1);
            default:             n_ll = r_ll;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ll    <= '0;
            r_width <= gwr_pkg::WIDTH_DEFAULT;
        end else begin
            r_ll <= n_ll;
            if (i_cfg.valid) begin
                r_width <= i_cfg.line_width;
            end
        end
    end

    always_comb begin
        case (i_cmd.emit_sel)
            gwr_pkg::EM_CHAR:  n_ochar = ram_rdata;
            gwr_pkg::EM_SPACE: n_ochar = gwr_pkg::SPACE_CHAR;
            default:           n_ochar = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_okind <= (i_cmd.emit_sel == gwr_pkg::EM_EOL) ? gwr_pkg::KIND_EOL
                                                           : gwr_pkg::KIND_CHAR;
            r_ochar <= n_ochar;
            r_ocut  <= r_cut;
            r_olast <= i_cmd.emit_last;
        end
    end

    assign i_in.ready        = i_cmd.in_ready;
    assign i_cfg.ready       = 1'b1;
    assign o_out.valid       = r_ovalid;
    assign o_out.out_kind    = r_okind;
    assign o_out.out_char    = r_ochar;
    assign o_out.word_cut    = r_ocut;
    assign o_out.last_result = r_olast;

    assign o_sts.in_valid  = i_in.valid;
    assign o_sts.is_flush  = is_flush;
    assign o_sts.word_brk  = word_brk;
    assign o_sts.space_brk = space_brk;
    assign o_sts.idx_done  = (r_idx == r_cnt);
    assign o_sts.out_free  = out_free;
    assign o_sts.eop       = r_eop;

endmodule

`default_nettype wire

// ===== hw/rtl/greedy_word_wrap_unit.sv =====
// Greedy word wrap unit. A word character is taken and gives no result.
// A space or end marker starts a flush: a break test (end of line first if the word does not
// fit), then for each buffered char a word RAM registered read and an output load, a check
// that the word is done, then a space break test and the space, or the end of line for an
// end marker. Each step that loads the output waits while the output register is full.
// Sync active-low reset clears counters and output valid flag, sets line width to 80.
`default_nettype none

module greedy_word_wrap_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gwr_in_if.sink    i_in,
    gwr_out_if.source o_out,
    gwr_cfg_if.sink   i_cfg
);

    gwr_pkg::t_cmd cmd;
    gwr_pkg::t_sts sts;

    gwr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gwr_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

    // a new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded while output register busy");

    // a flush item closes the input until its results are out
    a_flush_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && sts.is_flush) |=> !i_in.ready)
        else $error("input open during flush");

    // the final result of an item returns the unit to accepting input
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit && cmd.emit_last) |=> i_in.ready)
        else $error("not idle after final result");

    // inputs are only taken when nothing is being emitted
    a_take_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !cmd.emit)
        else $error("emit while accepting input");

endmodule

`default_nettype wire
